/* design/label_bit_vote_downsample_defines.svh */
// Assertion macros for the label bit vote downsampler.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef LABEL_BIT_VOTE_DOWNSAMPLE_DEFINES_SVH
`define LABEL_BIT_VOTE_DOWNSAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LBVD_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbvd same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define LBVD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbvd next-cycle check failed");
`else
`define LBVD_ASSERT_IMPLIES(lbl, ante, cons)
`define LBVD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/lbvd_pkg.sv */
// Shared types and constants of the label bit vote downsampler.
// No dependencies; used by the counter memory and the top level.
package lbvd_pkg;

   localparam int NUM_CLASSES    = 8;
   localparam int CNT_W          = 8;
   localparam int THR_W          = 5;
   localparam int SIZE_W         = 9;
   localparam int MAX_BLOCK_ROWS = 256;
   localparam int CSR_ADDR_W     = 5;

   typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] cnt_vec_type;

   typedef enum logic [2:0] {
      REG_GROUPS_PER_ROW = 3'd0,
      REG_BLOCK_ROWS     = 3'd1,
      REG_FULL_THR       = 3'd2,
      REG_ITEM_THR       = 3'd3,
      REG_ITEM_MASK      = 3'd4
   } reg_addr_type;

endpackage

/* design/lbvd_cnt_ram.sv */
// Counter memory: one row of eight bit counters per output column.
// Depends on lbvd_pkg; sweeps every row to zero after reset.
module lbvd_cnt_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output lbvd_pkg::cnt_vec_type rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  lbvd_pkg::cnt_vec_type wr_data,
   output logic                 clear_busy
);
   import lbvd_pkg::*;

   cnt_vec_type mem [DEPTH];
   cnt_vec_type rd_data_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clearing_ff;
   logic          clearing_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   cnt_vec_type   mem_wd;

   // sweep one row a cycle until the last row is zero
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we = clearing_ff | wr_en;
   assign mem_wa = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wd = clearing_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule

/* design/label_bit_vote_downsample.sv */
// Top level of the label bit vote downsampler: stream ports, register file,
// raster position tracking, counter update and vote. Depends on lbvd_pkg,
// lbvd_cnt_ram and label_bit_vote_downsample_defines.svh.
//
// Accepts one 8-bit label item per cycle on req_ and, for every 2^BLOCK_LOG2
// square block of source pixels, returns one voted label on rsp_ when the
// block's bottom-right pixel arrives; tuser flags a nonzero label and tlast
// marks the frame's last output pixel. Sustained rate is one item per clock
// outside the reset sweep and while the output is not blocked: each item makes
// a single read-modify-write of its column's counter row in a one-port-read,
// one-port-write memory, and a back-to-back hit on the same row is served
// from the value just written. A result passes from stage 1 into an output
// register, so new items are still taken while it waits there, until a
// second result reaches stage 1. After reset the counter memory is swept to
// zero, one row a clock; req_tready stays low meanwhile, though register
// writes are taken. Register map (32-bit, byte address 4*i): groups_per_row,
// block_rows, full_threshold, item_threshold, item_bit_mask. Sizes of zero
// count as one and oversize values saturate.
`include "label_bit_vote_downsample_defines.svh"
module label_bit_vote_downsample #(
   parameter int MAX_OUT_WIDTH = 256,
   parameter int BLOCK_LOG2    = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] label_in
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] label_out
   output logic                            rsp_tuser,   // [0] label_valid
   output logic                            rsp_tlast,   // frame_end
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lbvd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import lbvd_pkg::*;

   localparam int AW       = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int WW       = $clog2(MAX_OUT_WIDTH + 1);
   localparam int BLK      = 1 << BLOCK_LOG2;
   localparam int HW       = SIZE_W;
   localparam int CMP_W    = 12;

   // ---------------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------------
   logic [SIZE_W-1:0]      gpr_ff;
   logic [SIZE_W-1:0]      brows_ff;
   logic [THR_W-1:0]       full_thr_ff;
   logic [THR_W-1:0]       item_thr_ff;
   logic [NUM_CLASSES-1:0] item_mask_ff;
   logic                   csr_wr;
   reg_addr_type           csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = reg_addr_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_ff       <= SIZE_W'(64);
         brows_ff     <= SIZE_W'(64);
         full_thr_ff  <= THR_W'(16);
         item_thr_ff  <= THR_W'(10);
         item_mask_ff <= NUM_CLASSES'(8'h30);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GROUPS_PER_ROW: gpr_ff       <= csr_pwdata[SIZE_W-1:0];
            REG_BLOCK_ROWS:     brows_ff     <= csr_pwdata[SIZE_W-1:0];
            REG_FULL_THR:       full_thr_ff  <= csr_pwdata[THR_W-1:0];
            REG_ITEM_THR:       item_thr_ff  <= csr_pwdata[THR_W-1:0];
            REG_ITEM_MASK:      item_mask_ff <= csr_pwdata[NUM_CLASSES-1:0];
            default: begin
               // unmapped address: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GROUPS_PER_ROW: csr_prdata = 32'(gpr_ff);
         REG_BLOCK_ROWS:     csr_prdata = 32'(brows_ff);
         REG_FULL_THR:       csr_prdata = 32'(full_thr_ff);
         REG_ITEM_THR:       csr_prdata = 32'(item_thr_ff);
         REG_ITEM_MASK:      csr_prdata = 32'(item_mask_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Effective sizes: zero counts as one, oversize saturates.
   logic [WW-1:0] width_c;
   logic [HW-1:0] height_c;

   always_comb begin
      if (gpr_ff == '0) begin
         width_c = WW'(1);
      end else if (CMP_W'(gpr_ff) > CMP_W'(MAX_OUT_WIDTH)) begin
         width_c = WW'(MAX_OUT_WIDTH);
      end else begin
         width_c = WW'(gpr_ff);
      end
      if (brows_ff == '0) begin
         height_c = HW'(1);
      end else if (brows_ff > HW'(MAX_BLOCK_ROWS)) begin
         height_c = HW'(MAX_BLOCK_ROWS);
      end else begin
         height_c = brows_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 0: raster position, counter row read
   // ---------------------------------------------------------------------------
   logic [AW-1:0]         group_ff, group_in;
   logic [BLOCK_LOG2-1:0] sub_ff, sub_in;
   logic [BLOCK_LOG2-1:0] rib_ff, rib_in;
   logic [7:0]            blk_ff, blk_in;

   logic                  clear_busy;
   logic                  accept;
   logic [AW-1:0]         group_eff;
   logic [BLOCK_LOG2-1:0] sub_eff;
   logic [7:0]            blk_eff;
   logic                  col_restart;
   logic                  row_end;
   logic                  emit_c;
   logic                  frame_end_c;
   logic [HW-1:0]         blk_inc;

   // stage 1 and output register
   logic                  s1_valid_ff, s1_valid_in;
   logic [AW-1:0]         s1_addr_ff;
   logic [7:0]            s1_label_ff;
   logic                  s1_emit_ff;
   logic                  s1_last_ff;
   logic                  s1_adv;
   logic                  fwd_ff, fwd_in;
   cnt_vec_type           fwd_data_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]            rsp_label_ff;
   logic                  rsp_last_ff;

   assign col_restart = WW'(group_ff) >= width_c;
   assign group_eff   = col_restart ? '0 : group_ff;
   assign sub_eff     = col_restart ? '0 : sub_ff;
   assign blk_eff     = (HW'(blk_ff) >= height_c) ? '0 : blk_ff;

   assign row_end     = (sub_eff == BLOCK_LOG2'(BLK - 1)) &&
                        (WW'(group_eff) == width_c - 1'b1);
   assign emit_c      = (sub_eff == BLOCK_LOG2'(BLK - 1)) &&
                        (rib_ff == BLOCK_LOG2'(BLK - 1));
   assign frame_end_c = (WW'(group_eff) == width_c - 1'b1) &&
                        (HW'(blk_eff) == height_c - 1'b1);
   assign blk_inc     = HW'(blk_eff) + 1'b1;

   // Stage 1 may move on unless it carries a result and the output is blocked.
   assign s1_adv      = !s1_emit_ff || !rsp_tvalid_ff || rsp_tready;
   assign req_tready  = !clear_busy && (!s1_valid_ff || s1_adv);
   assign accept      = req_tvalid && req_tready;

   // advance the raster position on every accepted item
   always_comb begin
      group_in = group_ff;
      sub_in   = sub_ff;
      rib_in   = rib_ff;
      blk_in   = blk_ff;
      if (accept) begin
         sub_in   = sub_eff + 1'b1;
         group_in = group_eff;
         blk_in   = blk_eff;
         if (sub_eff == BLOCK_LOG2'(BLK - 1)) begin
            group_in = AW'(WW'(group_eff) + 1'b1);
         end
         if (row_end) begin
            group_in = '0;
            rib_in   = rib_ff + 1'b1;
            if (rib_ff == BLOCK_LOG2'(BLK - 1)) begin
               blk_in = (blk_inc >= height_c) ? '0 : blk_inc[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         sub_ff   <= '0;
         rib_ff   <= '0;
         blk_ff   <= '0;
      end else begin
         group_ff <= group_in;
         sub_ff   <= sub_in;
         rib_ff   <= rib_in;
         blk_ff   <= blk_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Counter memory
   // ---------------------------------------------------------------------------
   cnt_vec_type rd_data;
   cnt_vec_type base_cnt;
   cnt_vec_type new_cnt;
   cnt_vec_type wr_data;
   logic        wr_en;

   lbvd_cnt_ram #(
      .DEPTH (MAX_OUT_WIDTH),
      .AW    (AW)
   ) u_cnt_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (group_eff),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (s1_addr_ff),
      .wr_data    (wr_data),
      .clear_busy (clear_busy)
   );

   // ---------------------------------------------------------------------------
   // Stage 1: add the item's bits, vote, write back (cleared when the block ends)
   // ---------------------------------------------------------------------------
   logic [7:0] vote_c;

   // The row read alongside a write to the same row comes back stale: take the
   // value that write carried instead.
   assign base_cnt = fwd_ff ? fwd_data_ff : rd_data;

   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         new_cnt[i] = base_cnt[i] + CNT_W'(s1_label_ff[i]);
         vote_c[i]  = new_cnt[i] >= CNT_W'(item_mask_ff[i] ? item_thr_ff : full_thr_ff);
      end
   end

   assign wr_en   = s1_valid_ff && s1_adv;
   assign wr_data = s1_emit_ff ? '0 : new_cnt;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      fwd_in      = fwd_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         fwd_in      = wr_en && (s1_addr_ff == group_eff);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
         fwd_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= group_eff;
         s1_label_ff <= req_tdata;
         s1_emit_ff  <= emit_c;
         s1_last_ff  <= frame_end_c;
         fwd_data_ff <= wr_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   logic rsp_load;

   assign rsp_load = s1_valid_ff && s1_emit_ff && s1_adv;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_label_ff <= vote_c;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_label_ff;
   assign rsp_tuser  = rsp_label_ff != '0;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // no item enters while the counter memory is being swept
   `LBVD_ASSERT_IMPLIES(a_no_accept_in_sweep, clear_busy, !req_tready)
   // a bypassed row belongs to an item that is still in stage 1
   `LBVD_ASSERT_IMPLIES(a_fwd_needs_item, fwd_ff, s1_valid_ff)
   // a result appears only out of an item held in stage 1
   `LBVD_ASSERT_NEXT(a_result_has_source, !s1_valid_ff && !rsp_tvalid_ff, !rsp_tvalid_ff)

endmodule
